@@ hdl/rcam_pkg.sv @@
// ----------------------------------------------------------------------------
// rcam_pkg
// Shared constants, types and helpers of the region color abnormality monitor.
// ----------------------------------------------------------------------------
package rcam_pkg;

    // Geometry and history depth
    localparam int NUM_REGIONS = 4;
    localparam int SEQ_LEN     = 10;
    localparam int COORD_BITS  = 12;

    // Field and state widths
    localparam int PIX_W      = 8;
    localparam int RECT_W     = 4 * COORD_BITS;
    localparam int TT_W       = 16;
    localparam int RC_W       = 3;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 24;
    localparam int FC_W       = 32;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int FILL_W     = $clog2(SEQ_LEN + 1);
    localparam int NRM_W      = FILL_W + 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_CNT = 3'd1;
    localparam int                   CFG_RECT_BASE  = 2;

    // Reset values
    localparam logic [TT_W-1:0] TT_RST = TT_W'(30);

    // Sampling period = time_threshold * 10 / SEQ_LEN, by reciprocal multiply
    localparam int PRD_W     = TT_W + 4;
    localparam int REC_SHIFT = PRD_W + 6;
    localparam int PROD_W    = PRD_W + REC_SHIFT + 1;
    localparam logic [REC_SHIFT:0] REC_MUL =
        (REC_SHIFT+1)'(((64'd1 << REC_SHIFT) + 64'(SEQ_LEN) - 64'd1) / 64'(SEQ_LEN));
    localparam int PRD_RST_Q = (30 * 10) / SEQ_LEN;
    localparam logic [PRD_W-1:0] PRD_RST =
        (PRD_RST_Q == 0) ? PRD_W'(1) : PRD_W'(PRD_RST_Q);

    // Remainder unit step count
    localparam int MOD_CNT_W = $clog2(FC_W);

    // Mark and report thresholds
    localparam logic [SUM_W-1:0] BLUE_HI     = SUM_W'(150);
    localparam logic [SUM_W-1:0] DARK_LO     = SUM_W'(60);
    localparam logic [NRM_W-1:0] NORM_WEIGHT = NRM_W'(10);
    localparam logic [NRM_W-1:0] NORM_LIMIT  = NRM_W'(3 * SEQ_LEN);
    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;

    // One input pixel
    typedef struct packed {
        logic [PIX_W-1:0]      blue;
        logic [PIX_W-1:0]      green;
        logic [PIX_W-1:0]      red;
        logic [COORD_BITS-1:0] pix_x;
        logic [COORD_BITS-1:0] pix_y;
        logic                  frame_end;
    } t_pixel;

    // Per-slot control from the top level
    typedef struct packed {
        logic in_use;
        logic clear;
        logic acc;
        logic fin;
        logic fin_sampled;
    } t_slot_ctrl;

    // Timer status to the top level
    typedef struct packed {
        logic busy;
        logic sampled;
    } t_tmr_status;

    // Period / phase unit states
    typedef enum logic [1:0] {
        TMR_IDLE,
        TMR_SCALE,
        TMR_MOD
    } t_tmr_state;

    // Number of normal marks in a history word
    function automatic logic [FILL_W-1:0] ones_count(input logic [SEQ_LEN-1:0] v);
        logic [FILL_W-1:0] c;
        c = '0;
        for (int k = 0; k < SEQ_LEN; k++) begin
            c = c + FILL_W'(v[k]);
        end
        return c;
    endfunction

endpackage

@@ hdl/rcam_timer.sv @@
// ----------------------------------------------------------------------------
// rcam_timer
// Configuration registers, frame counter and sampling phase. A write of the
// time threshold rescales the period and recomputes the phase as the frame
// counter modulo the period, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcam_timer
    import rcam_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]               i_cfg_data,
    input  logic                                i_frame_adv,
    output t_tmr_status                         o_status,
    output logic [RC_W-1:0]                     o_region_cnt,
    output logic [NUM_REGIONS-1:0][RECT_W-1:0]  o_rects,
    output logic [NUM_REGIONS-1:0]              o_rect_clr
);

    t_tmr_state r_state, n_state;

    logic [TT_W-1:0]                    r_tt;
    logic [RC_W-1:0]                    r_rc;
    logic [NUM_REGIONS-1:0][RECT_W-1:0] r_rects;
    logic [PRD_W-1:0]                   r_period;
    logic [PRD_W-1:0]                   r_phase;
    logic [FC_W-1:0]                    r_fc;
    logic [FC_W-1:0]                    r_div;
    logic [PRD_W-1:0]                   r_rem;
    logic [MOD_CNT_W-1:0]               r_cnt;

    logic                               cfg_wr;
    logic [PRD_W-1:0]                   tt_x10;
    logic [PROD_W-1:0]                  prod;
    logic [PRD_W-1:0]                   quot;
    logic [PRD_W-1:0]                   n_period;
    logic [PRD_W:0]                     rem_sh;
    logic [PRD_W:0]                     rem_sub;
    logic [PRD_W-1:0]                   n_rem;
    logic [PRD_W:0]                     phase_inc;

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = (r_state == TMR_IDLE);

    // Period scaling: floor(tt*10 / SEQ_LEN), zero treated as one
    assign tt_x10   = (PRD_W'(r_tt) << 3) + (PRD_W'(r_tt) << 1);
    assign prod     = PROD_W'(tt_x10) * PROD_W'(REC_MUL);
    assign quot     = prod[REC_SHIFT +: PRD_W];
    assign n_period = (quot == '0) ? PRD_W'(1) : quot;

    // One restoring remainder step
    assign rem_sh  = {r_rem, r_div[FC_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_period};
    assign n_rem   = (rem_sh >= {1'b0, r_period}) ? rem_sub[PRD_W-1:0] : rem_sh[PRD_W-1:0];

    assign phase_inc = {1'b0, r_phase} + (PRD_W+1)'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            TMR_IDLE: begin
                if (cfg_wr && i_cfg_index == CFG_TIME_THR) begin
                    n_state = TMR_SCALE;
                end
            end
            TMR_SCALE: begin
                n_state = TMR_MOD;
            end
            TMR_MOD: begin
                if (r_cnt == MOD_CNT_W'(FC_W - 1)) begin
                    n_state = TMR_IDLE;
                end
            end
            default: begin
                n_state = TMR_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TMR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tt    <= TT_RST;
            r_rc    <= '0;
            r_rects <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_TIME_THR) begin
                r_tt <= i_cfg_data[TT_W-1:0];
            end
            if (i_cfg_index == CFG_REGION_CNT) begin
                r_rc <= i_cfg_data[RC_W-1:0];
            end
            for (int s = 0; s < NUM_REGIONS; s++) begin
                if (i_cfg_index == CFG_IDX_W'(CFG_RECT_BASE + s)) begin
                    r_rects[s] <= i_cfg_data[RECT_W-1:0];
                end
            end
        end
    end

    // Rectangle write clears that slot
    always_comb begin
        for (int s = 0; s < NUM_REGIONS; s++) begin
            o_rect_clr[s] = cfg_wr && (i_cfg_index == CFG_IDX_W'(CFG_RECT_BASE + s));
        end
    end

    // Period, phase, frame counter and remainder datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PRD_RST;
            r_phase  <= '0;
            r_fc     <= '0;
            r_div    <= '0;
            r_rem    <= '0;
            r_cnt    <= '0;
        end else begin
            case (r_state)
                TMR_IDLE: begin
                    if (i_frame_adv) begin
                        r_fc <= r_fc + FC_W'(1);
                        if (r_fc == '1 || phase_inc == {1'b0, r_period}) begin
                            r_phase <= '0;
                        end else begin
                            r_phase <= phase_inc[PRD_W-1:0];
                        end
                    end
                end
                TMR_SCALE: begin
                    r_period <= n_period;
                    r_div    <= r_fc;
                    r_rem    <= '0;
                    r_cnt    <= '0;
                end
                TMR_MOD: begin
                    r_rem <= n_rem;
                    r_div <= r_div << 1;
                    r_cnt <= r_cnt + MOD_CNT_W'(1);
                    if (r_cnt == MOD_CNT_W'(FC_W - 1)) begin
                        r_phase <= n_rem;
                    end
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    assign o_status.busy    = (r_state != TMR_IDLE);
    assign o_status.sampled = (r_phase == '0);
    assign o_region_cnt     = r_rc;
    assign o_rects          = r_rects;

endmodule

@@ hdl/rcam_slot.sv @@
// ----------------------------------------------------------------------------
// rcam_slot
// One monitored region: color sums and pixel count, frame mark, mark history
// and the abnormal report bit.
// ----------------------------------------------------------------------------
module rcam_slot
    import rcam_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_slot_ctrl        i_ctrl,
    input  logic [RECT_W-1:0] i_rect,
    input  t_pixel            i_pix,
    output logic              o_abnormal
);

    logic [SUM_W-1:0]   r_blue, r_green, r_red;
    logic [CNT_W-1:0]   r_cnt;
    logic [SEQ_LEN-1:0] r_hist;
    logic [FILL_W-1:0]  r_fill;

    logic [COORD_BITS-1:0] rx, ry, rw, rh;
    logic [COORD_BITS:0]   x_end, y_end;
    logic                  in_rect, hit, fin_upd;
    logic [SUM_W-1:0]      base_b, base_g, base_r;
    logic [CNT_W-1:0]      base_n;
    logic [SUM_W-1:0]      n_blue, n_green, n_red;
    logic [CNT_W-1:0]      n_cnt;
    logic [SUM_W-1:0]      n150, n60;
    logic [SUM_W:0]        gr_sum;
    logic                  bluish, dark, mark;
    logic [SEQ_LEN:0]      hist_sh;
    logic [SEQ_LEN-1:0]    hist_cur;
    logic [FILL_W-1:0]     fill_new, fill_cur;
    logic [NRM_W-1:0]      norm10;

    // Rectangle hit test
    assign rx      = i_rect[0*COORD_BITS +: COORD_BITS];
    assign ry      = i_rect[1*COORD_BITS +: COORD_BITS];
    assign rw      = i_rect[2*COORD_BITS +: COORD_BITS];
    assign rh      = i_rect[3*COORD_BITS +: COORD_BITS];
    assign x_end   = {1'b0, rx} + {1'b0, rw};
    assign y_end   = {1'b0, ry} + {1'b0, rh};
    assign in_rect = (i_pix.pix_x >= rx) && ({1'b0, i_pix.pix_x} < x_end) &&
                     (i_pix.pix_y >= ry) && ({1'b0, i_pix.pix_y} < y_end);
    assign hit     = i_ctrl.acc && i_ctrl.in_use && in_rect && (r_cnt != COUNT_MAX);

    // Frame close on a sampled frame restarts the sums
    assign fin_upd = i_ctrl.fin && i_ctrl.fin_sampled && i_ctrl.in_use;
    assign base_b  = fin_upd ? '0 : r_blue;
    assign base_g  = fin_upd ? '0 : r_green;
    assign base_r  = fin_upd ? '0 : r_red;
    assign base_n  = fin_upd ? '0 : r_cnt;

    assign n_blue  = base_b + (hit ? SUM_W'(i_pix.blue)  : '0);
    assign n_green = base_g + (hit ? SUM_W'(i_pix.green) : '0);
    assign n_red   = base_r + (hit ? SUM_W'(i_pix.red)   : '0);
    assign n_cnt   = base_n + CNT_W'(hit);

    // Mark: 1 = normal, integer compare of sums against scaled count
    assign n150   = SUM_W'(r_cnt) * BLUE_HI;
    assign n60    = SUM_W'(r_cnt) * DARK_LO;
    assign gr_sum = {1'b0, r_green} + {1'b0, r_red};
    assign bluish = (r_blue > n150) && ({1'b0, r_blue} > gr_sum);
    assign dark   = (r_blue < n60) && (r_green < n60) && (r_red < n60);
    assign mark   = (r_cnt != '0) && !bluish && !dark;

    // History after this frame
    assign hist_sh  = {r_hist, mark};
    assign hist_cur = fin_upd ? hist_sh[SEQ_LEN-1:0] : r_hist;
    assign fill_new = (r_fill == FILL_W'(SEQ_LEN)) ? r_fill : r_fill + FILL_W'(1);
    assign fill_cur = fin_upd ? fill_new : r_fill;

    // Report: full history, fewer than 30 percent normal
    assign norm10     = NRM_W'(ones_count(hist_cur)) * NORM_WEIGHT;
    assign o_abnormal = i_ctrl.in_use && (fill_cur >= FILL_W'(SEQ_LEN)) &&
                        (norm10 < NORM_LIMIT);

    // Slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_blue  <= '0;
            r_green <= '0;
            r_red   <= '0;
            r_cnt   <= '0;
            r_hist  <= '0;
            r_fill  <= '0;
        end else begin
            r_blue  <= n_blue;
            r_green <= n_green;
            r_red   <= n_red;
            r_cnt   <= n_cnt;
            if (fin_upd) begin
                r_hist <= hist_sh[SEQ_LEN-1:0];
                r_fill <= fill_new;
            end
        end
    end

endmodule

@@ hdl/roi_color_abnormal_monitor_top.sv @@
// ----------------------------------------------------------------------------
// roi_color_abnormal_monitor_top
// Region color abnormality monitor: per-region color accumulation, frame
// marks, mark history and abnormal report, one result per frame end.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock when not stalled and returns one
// result beat for each pixel flagged as frame end after that pixel is taken
// (accumulate out of the input register, then frame close into the output
// register). The output register and the two stages before it absorb
// back-pressure; the input stalls only once all three hold work. Writing the
// time threshold starts the period unit: it scales the period, then works
// out one remainder bit per cycle over the 32-bit frame counter, and the
// block stalls pixels and holds the configuration port until that is done.
// Other configuration writes take effect at once; a rectangle write clears
// that region's sums and history.
// ----------------------------------------------------------------------------
module roi_color_abnormal_monitor_top
    import rcam_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Pixel channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [PIX_W-1:0]       i_blue,
    input  logic [PIX_W-1:0]       i_green,
    input  logic [PIX_W-1:0]       i_red,
    input  logic [COORD_BITS-1:0]  i_pix_x,
    input  logic [COORD_BITS-1:0]  i_pix_y,
    input  logic                   i_frame_end,
    // Result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [MASK_W-1:0]      o_abnormal_mask,
    output logic                   o_frame_sampled,
    // Configuration channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_tmr_status                        status;
    logic [RC_W-1:0]                    region_cnt;
    logic [NUM_REGIONS-1:0][RECT_W-1:0] rects;
    logic [NUM_REGIONS-1:0]             rect_clr;
    logic [NUM_REGIONS-1:0]             abn_vec;
    t_slot_ctrl [NUM_REGIONS-1:0]       slot_ctrl;

    t_pixel                r_a;
    logic                  r_a_vld;
    logic                  r_b_vld;
    logic                  r_b_sampled;
    logic                  r_out_vld;
    logic [MASK_W-1:0]     r_out_mask;
    logic                  r_out_sampled;

    logic                  in_acc, a_adv, b_adv;

    // Stage handshakes
    assign b_adv   = r_b_vld && (!r_out_vld || !i_stall);
    assign a_adv   = r_a_vld && !status.busy && (!r_b_vld || b_adv);
    assign o_stall = status.busy || (r_a_vld && !a_adv);
    assign in_acc  = i_valid && !o_stall;

    rcam_timer u_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_frame_adv  (a_adv && r_a.frame_end),
        .o_status     (status),
        .o_region_cnt (region_cnt),
        .o_rects      (rects),
        .o_rect_clr   (rect_clr)
    );

    // Region slots
    for (genvar s = 0; s < NUM_REGIONS; s++) begin : g_slot
        assign slot_ctrl[s].in_use      = (RC_W'(s) < region_cnt);
        assign slot_ctrl[s].clear       = rect_clr[s];
        assign slot_ctrl[s].acc         = a_adv && status.sampled;
        assign slot_ctrl[s].fin         = b_adv;
        assign slot_ctrl[s].fin_sampled = r_b_sampled;

        rcam_slot u_slot (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (slot_ctrl[s]),
            .i_rect     (rects[s]),
            .i_pix      (r_a),
            .o_abnormal (abn_vec[s])
        );
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (in_acc) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a.blue      <= i_blue;
            r_a.green     <= i_green;
            r_a.red       <= i_red;
            r_a.pix_x     <= i_pix_x;
            r_a.pix_y     <= i_pix_y;
            r_a.frame_end <= i_frame_end;
        end
    end

    // Frame-close token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (!r_b_vld || b_adv) begin
            r_b_vld <= a_adv && r_a.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_b_vld || b_adv) begin
            r_b_sampled <= status.sampled;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (b_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out_mask    <= MASK_W'(abn_vec);
            r_out_sampled <= r_b_sampled;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_abnormal_mask = r_out_mask;
    assign o_frame_sampled = r_out_sampled;

endmodule

@@ sim/roi_color_abnormal_monitor_top_tb.sv @@
// ----------------------------------------------------------------------------
// roi_color_abnormal_monitor_top_tb
// Self-checking bench for the region color abnormality monitor.
// ----------------------------------------------------------------------------
// Short frames of colored pixels are pushed through regions that may be
// set up anew in each phase. A shadow copy of the per-region sums, counts and
// mark histories predicts every frame-end report (abnormal mask and sampled
// flag), and each result beat is checked against the oldest prediction. Both
// the pixel sender and the result receiver idle at random, with calm phases.
// ----------------------------------------------------------------------------
module roi_color_abnormal_monitor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcam_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int ITEMS_TARGET   = 2000;
    localparam int SETTLE         = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int THR_AT_RESET   = 30;
    localparam int DARK_LIMIT     = 60;
    localparam int BLUE_LIMIT     = 150;
    localparam int NORMAL_PCT     = 30;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

    // Register indexes past the last rectangle: writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_IDX_W'(CFG_RECT_BASE + NUM_REGIONS);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;

    // Directed pixels: color corners and mark thresholds, coordinate corners
    localparam int DIR_B [8] = '{255, 0, 255, 0,   151, 59, 60, 150};
    localparam int DIR_G [8] = '{255, 0, 0,   255, 0,   59, 60, 0};
    localparam int DIR_R [8] = '{255, 0, 0,   255, 0,   59, 60, 0};
    localparam int DIR_X [4] = '{4095, 0, 11, 12};
    localparam int DIR_Y [4] = '{4095, 0, 10, 11};

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              sampled;
    } t_frame_report;

    typedef enum {TONE_DARK, TONE_BLUE, TONE_MIXED, TONE_BRIGHT} t_tone;

    // ------------------------------------------------------------------------
    // Shadow of the region sums and mark histories, plus the reports owed
    // ------------------------------------------------------------------------
    class t_roi_history_tracker;
        logic [TT_W-1:0]    thr;
        logic [RC_W-1:0]    rcount;
        logic [RECT_W-1:0]  rect [NUM_REGIONS];
        logic [FC_W-1:0]    frames;
        logic [SUM_W-1:0]   bsum [NUM_REGIONS];
        logic [SUM_W-1:0]   gsum [NUM_REGIONS];
        logic [SUM_W-1:0]   rsum [NUM_REGIONS];
        logic [CNT_W-1:0]   npix [NUM_REGIONS];
        logic [SEQ_LEN-1:0] hist [NUM_REGIONS];
        int                 fill [NUM_REGIONS];
        t_frame_report      reports_due[$];
        int                 errors;
        int                 reports_seen;
        int                 sampled_frames;
        int                 flagged_frames;

        function new();
            thr            = TT_W'(THR_AT_RESET);
            rcount         = '0;
            frames         = '0;
            errors         = 0;
            reports_seen   = 0;
            sampled_frames = 0;
            flagged_frames = 0;
            for (int s = 0; s < NUM_REGIONS; s++) begin
                rect[s] = '0;
                clear_slot(s);
            end
        endfunction

        function void clear_slot(int s);
            bsum[s] = '0;
            gsum[s] = '0;
            rsum[s] = '0;
            npix[s] = '0;
            hist[s] = '0;
            fill[s] = 0;
        endfunction

        // region_count above the slot count saturates
        function int slots_used();
            return (rcount > NUM_REGIONS) ? NUM_REGIONS : int'(rcount);
        endfunction

        // k: 0 x, 1 y, 2 width, 3 height
        function int unsigned rect_field(int s, int k);
            return int'((rect[s] >> (k * COORD_BITS)) & RECT_W'(COORD_MAX));
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int s;
            s = int'(idx) - CFG_RECT_BASE;
            if (idx == CFG_TIME_THR) begin
                thr = data[TT_W-1:0];
            end else if (idx == CFG_REGION_CNT) begin
                rcount = data[RC_W-1:0];
            end else if (s >= 0 && s < NUM_REGIONS) begin
                rect[s] = data[RECT_W-1:0];
                clear_slot(s);
            end
        endfunction

        function void take_pixel(t_pixel p);
            int unsigned     period;
            int unsigned     px, py, x, y, w, h;
            longint unsigned n, b, g, r;
            int              used;
            bit              samp;
            bit              normal;
            t_frame_report   rep;

            used   = slots_used();
            period = (int'(thr) * 10) / SEQ_LEN;
            if (period == 0) begin
                period = 1;
            end
            samp = (frames % period) == 0;
            px   = p.pix_x;
            py   = p.pix_y;

            // accumulate pixels inside each region, count saturates
            if (samp) begin
                for (int s = 0; s < used; s++) begin
                    x = rect_field(s, 0);
                    y = rect_field(s, 1);
                    w = rect_field(s, 2);
                    h = rect_field(s, 3);
                    if (px >= x && px < x + w && py >= y && py < y + h && !(&npix[s])) begin
                        bsum[s] += p.blue;
                        gsum[s] += p.green;
                        rsum[s] += p.red;
                        npix[s] += 1'b1;
                    end
                end
            end

            if (!p.frame_end) begin
                return;
            end

            // frame close: mark each region and shift into its history
            rep.mask    = '0;
            rep.sampled = samp;
            if (samp) begin
                sampled_frames++;
                for (int s = 0; s < used; s++) begin
                    n      = npix[s];
                    b      = bsum[s];
                    g      = gsum[s];
                    r      = rsum[s];
                    normal = 1'b1;
                    if (n == 0) begin
                        normal = 1'b0;
                    end else if (b > BLUE_LIMIT * n && b > g + r) begin
                        normal = 1'b0;
                    end else if (b < DARK_LIMIT * n && g < DARK_LIMIT * n && r < DARK_LIMIT * n) begin
                        normal = 1'b0;
                    end
                    hist[s] = (hist[s] << 1) | SEQ_LEN'(normal);
                    if (fill[s] < SEQ_LEN) begin
                        fill[s]++;
                    end
                    bsum[s] = '0;
                    gsum[s] = '0;
                    rsum[s] = '0;
                    npix[s] = '0;
                end
            end

            // full history with too few normal marks is flagged
            for (int s = 0; s < used; s++) begin
                if (fill[s] >= SEQ_LEN && $countones(hist[s]) * 100 < NORMAL_PCT * SEQ_LEN) begin
                    rep.mask[s] = 1'b1;
                end
            end
            if (rep.mask != '0) begin
                flagged_frames++;
            end
            frames += 1'b1;
            reports_due = {reports_due, rep};
        endfunction

        task check_report(logic [MASK_W-1:0] mask, logic samp);
            t_frame_report want;
            if (reports_due.size() == 0) begin
                note_mismatch($sformatf("result beat with no frame pending: mask=%h sampled=%b",
                                        mask, samp));
                return;
            end
            want = reports_due.pop_front();
            if (mask !== want.mask) begin
                note_mismatch($sformatf("frame %0d abnormal_mask got %h want %h",
                                        reports_seen, mask, want.mask));
            end
            if (samp !== want.sampled) begin
                note_mismatch($sformatf("frame %0d frame_sampled got %b want %b",
                                        reports_seen, samp, want.sampled));
            end
            reports_seen++;
        endtask

        task note_mismatch(string what);
            errors++;
            $display("%0t: mismatch: %s", $time, what);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_blue          = '0;
    logic [PIX_W-1:0]      i_green         = '0;
    logic [PIX_W-1:0]      i_red           = '0;
    logic [COORD_BITS-1:0] i_pix_x         = '0;
    logic [COORD_BITS-1:0] i_pix_y         = '0;
    logic                  i_frame_end     = 1'b0;
    logic                  o_valid;
    logic                  i_stall         = 1'b0;
    logic [MASK_W-1:0]     o_abnormal_mask;
    logic                  o_frame_sampled;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    t_roi_history_tracker sb;
    bit calm          = 1'b0;
    int pixels_taken  = 0;
    int results_taken = 0;
    int phases        = 0;
    int quiet         = 0;
    int stall_left    = 0;

    roi_color_abnormal_monitor_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_blue          (i_blue),
        .i_green         (i_green),
        .i_red           (i_red),
        .i_pix_x         (i_pix_x),
        .i_pix_y         (i_pix_y),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_abnormal_mask (o_abnormal_mask),
        .o_frame_sampled (o_frame_sampled),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Idle run length: mostly none or short, now and then long
    function automatic int idle_len();
        int sel;
        if (calm) begin
            return 0;
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            return 0;
        end
        if (sel < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [RECT_W-1:0] pack_rect(int unsigned x, int unsigned y,
                                                    int unsigned w, int unsigned h);
        return {COORD_BITS'(h), COORD_BITS'(w), COORD_BITS'(y), COORD_BITS'(x)};
    endfunction

    // Mostly small rectangles near the origin, some arbitrary, some extreme
    function automatic logic [RECT_W-1:0] pick_rect();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            return pack_rect($urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 10), $urandom_range(0, 10));
        end
        if (sel < 85) begin
            return RECT_W'({$urandom, $urandom});
        end
        if (sel < 93) begin
            return pack_rect(0, 0, COORD_MAX, COORD_MAX);
        end
        return pack_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    endfunction

    function automatic t_pixel make_pixel(int unsigned b, int unsigned g, int unsigned r,
                                          int unsigned x, int unsigned y, bit fe);
        t_pixel p;
        p.blue      = PIX_W'(b);
        p.green     = PIX_W'(g);
        p.red       = PIX_W'(r);
        p.pix_x     = COORD_BITS'(x);
        p.pix_y     = COORD_BITS'(y);
        p.frame_end = fe;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One pixel beat; valid stays high after acceptance for back-to-back beats
    task automatic push_pixel(input t_pixel p);
        int gap;
        gap = idle_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_blue      <= p.blue;
        i_green     <= p.green;
        i_red       <= p.red;
        i_pix_x     <= p.pix_x;
        i_pix_y     <= p.pix_y;
        i_frame_end <= p.frame_end;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Register write; caller drops i_cfg_valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stop pixels, wait for every owed report, then let the pipe go quiet
    task automatic settle_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.reports_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One frame of a single tone; last pixel carries frame_end
    task automatic send_frame(input int abn_pct);
        t_tone       tone;
        int          len, sel, used, s;
        int unsigned b, g, r, px, py;
        if ($urandom_range(0, 99) < abn_pct) begin
            tone = ($urandom_range(0, 1) != 0) ? TONE_DARK : TONE_BLUE;
        end else begin
            tone = ($urandom_range(0, 1) != 0) ? TONE_MIXED : TONE_BRIGHT;
        end
        len  = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        used = sb.slots_used();
        for (int k = 0; k < len; k++) begin
            case (tone)
                TONE_DARK: begin
                    b = $urandom_range(0, 65);
                    g = $urandom_range(0, 65);
                    r = $urandom_range(0, 65);
                end
                TONE_BLUE: begin
                    b = $urandom_range(140, 255);
                    g = $urandom_range(0, 80);
                    r = $urandom_range(0, 80);
                end
                TONE_MIXED: begin
                    b = $urandom_range(0, 255);
                    g = $urandom_range(0, 255);
                    r = $urandom_range(0, 255);
                end
                default: begin
                    b = $urandom_range(0, 255);
                    g = $urandom_range(100, 255);
                    r = $urandom_range(100, 255);
                end
            endcase
            // anywhere, in or just around a region in use, or near the origin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                px = $urandom_range(0, COORD_MAX);
                py = $urandom_range(0, COORD_MAX);
            end else if (sel < 80 && used > 0) begin
                s  = $urandom_range(0, used - 1);
                px = sb.rect_field(s, 0) + $urandom_range(0, sb.rect_field(s, 2) + 1) - 1;
                py = sb.rect_field(s, 1) + $urandom_range(0, sb.rect_field(s, 3) + 1) - 1;
            end else begin
                px = $urandom_range(0, 23);
                py = $urandom_range(0, 23);
            end
            push_pixel(make_pixel(b, g, r, px, py, k == len - 1));
        end
    endtask

    // Result back-pressure: random free and stalled runs
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (calm || $urandom_range(0, 99) < 55) begin
            i_stall    <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            i_stall    <= 1'b1;
            stall_left <= idle_len();
        end
    end

    // ------------------------------------------------------------------------
    // Beat monitor, checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.apply_write(i_cfg_index, i_cfg_data);
            end
            if (i_valid && !o_stall) begin
                sb.take_pixel(t_pixel'({i_blue, i_green, i_red, i_pix_x, i_pix_y, i_frame_end}));
                pixels_taken++;
            end
            if (o_valid && !i_stall) begin
                sb.check_report(o_abnormal_mask, o_frame_sampled);
                results_taken++;
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d reports still owed",
                     quiet, sb.reports_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int sel;
        int thr_pick;
        int abn_pct;
        int nframes;

        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: no regions, first frame is sampled
        push_pixel(make_pixel(0, 0, 0, 0, 0, 1'b1));
        settle_idle();

        // zero threshold, all slots: full frame, far corner, empty, small square
        write_reg(CFG_TIME_THR, '0);
        write_reg(CFG_REGION_CNT, CFG_DATA_W'(NUM_REGIONS));
        write_reg(CFG_IDX_W'(CFG_RECT_BASE + 0), pack_rect(0, 0, COORD_MAX, COORD_MAX));
        write_reg(CFG_IDX_W'(CFG_RECT_BASE + 1), pack_rect(COORD_MAX, COORD_MAX, 1, 1));
        write_reg(CFG_IDX_W'(CFG_RECT_BASE + 2), pack_rect(0, 0, 0, 5));
        write_reg(CFG_IDX_W'(CFG_RECT_BASE + 3), pack_rect(10, 10, 2, 2));
        write_reg(CFG_UNUSED_FIRST, '1);
        i_cfg_valid <= 1'b0;

        // mostly single-pixel frames so histories fill and reports show up
        for (int k = 0; k < 20; k++) begin
            push_pixel(make_pixel(DIR_B[k % 8], DIR_G[k % 8], DIR_R[k % 8],
                                  DIR_X[k % 4], DIR_Y[k % 4], (k % 4) != 3));
        end

        // random phases, each with its own register setting
        while (pixels_taken < ITEMS_TARGET) begin
            settle_idle();
            if ($urandom_range(0, 99) < 50) begin
                sel = $urandom_range(0, 99);
                if (sel < 30) begin
                    thr_pick = 1;
                end else if (sel < 45) begin
                    thr_pick = 0;
                end else if (sel < 65) begin
                    thr_pick = 2;
                end else if (sel < 80) begin
                    thr_pick = 3;
                end else if (sel < 90) begin
                    thr_pick = $urandom_range(4, 12);
                end else if (sel < 95) begin
                    thr_pick = (1 << TT_W) - 1;
                end else begin
                    thr_pick = $urandom_range(0, (1 << TT_W) - 1);
                end
                write_reg(CFG_TIME_THR, CFG_DATA_W'(thr_pick));
            end
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                write_reg(CFG_REGION_CNT, CFG_DATA_W'(NUM_REGIONS));
            end else if (sel < 75) begin
                write_reg(CFG_REGION_CNT, CFG_DATA_W'($urandom_range(NUM_REGIONS + 1, 7)));
            end else begin
                write_reg(CFG_REGION_CNT, CFG_DATA_W'($urandom_range(0, NUM_REGIONS - 1)));
            end
            for (int s = 0; s < NUM_REGIONS; s++) begin
                if ($urandom_range(0, 99) < 40) begin
                    write_reg(CFG_IDX_W'(CFG_RECT_BASE + s), pick_rect());
                end
            end
            if ($urandom_range(0, 99) < 15) begin
                write_reg(($urandom_range(0, 1) != 0) ? CFG_UNUSED_FIRST : CFG_UNUSED_LAST,
                          CFG_DATA_W'({$urandom, $urandom}));
            end
            i_cfg_valid <= 1'b0;

            calm    = ($urandom_range(0, 3) == 0);
            abn_pct = $urandom_range(30, 90);
            nframes = $urandom_range(12, 36);
            repeat (nframes) send_frame(abn_pct);
            phases++;
        end
        settle_idle();

        $display("Run covered %0d pixels and %0d frame reports across %0d register settings.",
                 pixels_taken, results_taken, phases + 2);
        $display("%0d frames were sampled; %0d reports flagged at least one region.",
                 sb.sampled_frames, sb.flagged_frames);
        if (sb.errors == 0 && sb.reports_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
